// ===== rtl/bqdw_pkg.sv =====
// Shared types and constants for the biquad dry/wet filter.
// Holds register indexes, CSR port sizes and the MAC control struct.
// No dependencies.
package bqdw_pkg;

   localparam int CHANNELS_DEF       = 2;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 20;

   localparam int COEF_W     = 24;
   localparam int REG_COUNT  = 7;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_FEED0,
      REG_FEED1,
      REG_FEED2,
      REG_BACK1,
      REG_BACK2,
      REG_WET,
      REG_DRY
   } reg_index_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_LOAD
   } acc_op_type;

   typedef struct packed {
      logic       issue;
      logic       neg;
      acc_op_type acc_op;
   } mac_ctrl_type;

endpackage

// ===== rtl/bqdw_csr.sv =====
// Coefficient register bank behind the APB-style CSR port.
// Depends on bqdw_pkg.
module bqdw_csr
   import bqdw_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready,
   output logic signed [COEF_W-1:0]     coef [REG_COUNT]
);

   localparam logic [COEF_W-1:0] DRY_RESET = COEF_W'(64'd1 << COEF_FRAC_BITS);

   logic signed [COEF_W-1:0] coef_ff [REG_COUNT];
   reg_index_type            index;
   logic                     write_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[REG_DRY] <= DRY_RESET;
      end else if (write_en) begin
         unique case (index)
            REG_FEED0, REG_FEED1, REG_FEED2, REG_BACK1,
            REG_BACK2, REG_WET, REG_DRY: begin
               coef_ff[index] <= csr_pwdata[COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FEED0, REG_FEED1, REG_FEED2, REG_BACK1,
         REG_BACK2, REG_WET, REG_DRY: begin
            csr_prdata = CSR_DATA_W'(coef_ff[index]);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

// ===== rtl/bqdw_mac.sv =====
// Shared multiply-accumulate unit with round-to-nearest and saturation.
// Depends on bqdw_pkg.
module bqdw_mac
   import bqdw_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  ctrl,
   input  logic signed [COEF_W-1:0]      coef,
   input  logic signed [SAMPLE_BITS-1:0] operand,
   output logic signed [SAMPLE_BITS-1:0] sat_out
);

   localparam int PROD_W = COEF_W + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX    = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [ACC_W-1:0] SAT_MIN    = -SAT_MAX - 1;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  biased;
   logic signed [ACC_W-1:0]  shifted;

   assign prod_in = coef * operand;
   assign term    = neg_ff ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);

   always_comb begin
      case (ctrl.acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + term;
         ACC_LOAD:  acc_in = term;
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff <= prod_in;
         neg_ff  <= ctrl.neg;
      end
   end

   assign biased  = acc_ff + ROUND_HALF;
   assign shifted = biased >>> COEF_FRAC_BITS;

   always_comb begin
      if (shifted > SAT_MAX) begin
         sat_out = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_MIN) begin
         sat_out = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         sat_out = shifted[SAMPLE_BITS-1:0];
      end
   end

endmodule

// ===== rtl/biquad_dry_wet_filter_top.sv =====
// Biquad dry/wet filter top level: sequencer, per-channel history, output register.
// Depends on bqdw_pkg, bqdw_csr and bqdw_mac.
//
// Per-channel direct form I biquad with a dry/wet mix. One multiplier is shared over
// seven products in sequence: five feed-forward/feedback terms build the wet value,
// which is rounded and saturated, then dry and wet gains build the output. After an
// item for a valid channel is accepted req_tready stays low through six multiplier
// issues, the rounding of the wet value, one issue for the wet gain, one accumulate
// and one output rounding step, so a new transaction is accepted only once the
// sequencer is back in idle. The result sits in an output register, so the next
// transaction may start while it waits; the block stalls before its own result only
// if the previous one is still not taken. Write coefficients only while idle.
module biquad_dry_wet_filter_top
   import bqdw_pkg::*;
#(
   parameter int CHANNELS       = CHANNELS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int DATA_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [SAMPLE_BITS-1:0] sample_in
   input  logic                  req_tuser,   // [0] chan
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // [SAMPLE_BITS-1:0] sample_out
   output logic                  rsp_tuser,   // [0] chan_out
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WET,
      ST_MIX,
      ST_DRAIN,
      ST_ROUND
   } state_type;

   typedef enum logic [2:0] {
      TERM_FEED0,
      TERM_FEED1,
      TERM_FEED2,
      TERM_BACK1,
      TERM_BACK2,
      TERM_DRY,
      TERM_WET
   } term_type;

   logic signed [COEF_W-1:0]      coef [REG_COUNT];
   mac_ctrl_type                  mac_ctrl;
   logic signed [COEF_W-1:0]      mac_coef;
   logic signed [SAMPLE_BITS-1:0] mac_operand;
   logic signed [SAMPLE_BITS-1:0] mac_sat;

   state_type                     state_ff, state_in;
   term_type                      term_ff, term_in;
   logic                          chan_ff;
   logic                          bad_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [SAMPLE_BITS-1:0] wet_ff;
   logic signed [SAMPLE_BITS-1:0] x1_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] x2_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y1_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] y2_ff [CHANNELS];
   logic                          rsp_valid_ff;
   logic                          rsp_chan_ff;
   logic [SAMPLE_BITS-1:0]        rsp_sample_ff;

   logic                          req_fire;
   logic                          round_fire;
   logic                          chan_ok;
   logic [CH_W-1:0]               ch_idx;

   bqdw_csr #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .coef       (coef)
   );

   bqdw_mac #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .coef   (mac_coef),
      .operand(mac_operand),
      .sat_out(mac_sat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign chan_ok    = 32'(req_tuser) < CHANNELS;
   assign ch_idx     = CH_W'(chan_ff);
   assign round_fire = (state_ff == ST_ROUND) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tdata  = DATA_W'(rsp_sample_ff);

   always_comb begin
      case (term_ff)
         TERM_FEED0: begin
            mac_coef    = coef[REG_FEED0];
            mac_operand = x_ff;
         end
         TERM_FEED1: begin
            mac_coef    = coef[REG_FEED1];
            mac_operand = x1_ff[ch_idx];
         end
         TERM_FEED2: begin
            mac_coef    = coef[REG_FEED2];
            mac_operand = x2_ff[ch_idx];
         end
         TERM_BACK1: begin
            mac_coef    = coef[REG_BACK1];
            mac_operand = y1_ff[ch_idx];
         end
         TERM_BACK2: begin
            mac_coef    = coef[REG_BACK2];
            mac_operand = y2_ff[ch_idx];
         end
         TERM_DRY: begin
            mac_coef    = coef[REG_DRY];
            mac_operand = x_ff;
         end
         TERM_WET: begin
            mac_coef    = coef[REG_WET];
            mac_operand = wet_ff;
         end
         default: begin
            mac_coef    = '0;
            mac_operand = '0;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      term_in         = term_ff;
      mac_ctrl.issue  = 1'b0;
      mac_ctrl.neg    = (term_ff == TERM_BACK1) || (term_ff == TERM_BACK2);
      mac_ctrl.acc_op = ACC_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            mac_ctrl.acc_op = ACC_CLEAR;
            term_in         = TERM_FEED0;
            if (req_fire) begin
               state_in = chan_ok ? ST_ISSUE : ST_ROUND;
            end
         end
         ST_ISSUE: begin
            mac_ctrl.issue  = 1'b1;
            mac_ctrl.acc_op = (term_ff == TERM_FEED0) ? ACC_HOLD : ACC_ADD;
            if (term_ff == TERM_DRY) begin
               term_in  = TERM_WET;
               state_in = ST_WET;
            end else begin
               term_in = term_type'(term_ff + 3'd1);
            end
         end
         ST_WET: begin
            mac_ctrl.acc_op = ACC_LOAD;
            state_in        = ST_MIX;
         end
         ST_MIX: begin
            mac_ctrl.issue = 1'b1;
            state_in       = ST_DRAIN;
         end
         ST_DRAIN: begin
            mac_ctrl.acc_op = ACC_ADD;
            state_in        = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_FEED0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         if (round_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (round_fire) begin
            rsp_chan_ff   <= chan_ff;
            rsp_sample_ff <= bad_ff ? '0 : mac_sat;
         end
         if (round_fire && !bad_ff) begin
            x2_ff[ch_idx] <= x1_ff[ch_idx];
            x1_ff[ch_idx] <= x_ff;
            y2_ff[ch_idx] <= y1_ff[ch_idx];
            y1_ff[ch_idx] <= wet_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff    <= req_tdata[SAMPLE_BITS-1:0];
         chan_ff <= req_tuser;
         bad_ff  <= !chan_ok;
      end
      if (state_ff == ST_WET) begin
         wet_ff <= mac_sat;
      end
   end

endmodule
